### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by bqf_checker
// Clocked on clk_i, switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/bqf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_pkg
// Widths, register indexes and sequencer states of the biquad filter.
// ----------------------------------------------------------------------------
package bqf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 32;
  localparam int STATE_W   = 40;
  localparam int COEF_FRAC = COEF_W - 2;
  // state operands go through the multiplier in two halves
  localparam int SPLIT_W   = STATE_W / 2;
  localparam int MULB_W    = STATE_W - SPLIT_W + 1;
  localparam int PROD_W    = COEF_W + MULB_W;
  localparam int ACC_W     = COEF_W + STATE_W + 4;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'sd1 <<< COEF_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0,
    CFG_B1,
    CFG_B2,
    CFG_A0,
    CFG_A1,
    CFG_A2,
    CFG_MODE
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_W,
    ST_DRAIN_W,
    ST_ROUND_W,
    ST_MUL_Y,
    ST_DRAIN_Y,
    ST_ROUND_Y,
    ST_PUSH
  } state_e;

endpackage

### hdl/biquad_iir_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Direct form II biquad on Q1.23 samples, Q2.30 coefficients, one shared
// 32 x 21 multiplier and one 76-bit accumulator under a small sequencer.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata[23:0] sample_in, tlast block_end
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata[23:0] sample_out, tlast block_end_out
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One sample is taken at a time, only in idle; the sequencer then runs six multiplier
// passes for w, six for y (each 32x40 product in two halves), plus drain, round and
// push steps before the result reaches the output register.
// A new sample is taken in idle even while the previous result waits.
// The push step stalls only if the output register still holds an untaken result.
// Reset (rst_ni low, asynchronous) restores coefficients and clears both delays.
// ----------------------------------------------------------------------------
module biquad_iir_filter import bqf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,   // [23:0] sample_in
  input  logic                 s_axis_tlast,   // block_end
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata,   // [23:0] sample_out
  output logic                 m_axis_tlast,   // block_end_out
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i
);

  state_e state_q, state_d;
  logic [2:0] op_q, op_d;

  logic signed [COEF_W-1:0] coef_b0_q, coef_b1_q, coef_b2_q;
  logic signed [COEF_W-1:0] coef_a0_q, coef_a1_q, coef_a2_q;
  logic                     mode_q;

  logic signed [SAMPLE_W-1:0] x_q;
  logic                       last_q;
  logic signed [STATE_W-1:0]  w_q, d1_q, d2_q;
  logic signed [SAMPLE_W-1:0] y_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic                       prod_hi_q, prod_sub_q, pv_q;
  logic signed [ACC_W-1:0]    acc_q;

  logic [SAMPLE_W-1:0] out_data_q;
  logic                out_last_q, out_valid_q;

  logic s_hs, m_hs, issue, phase_y, do_round_w, do_round_y, push_go;
  logic sub_sel;
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [STATE_W-1:0] opnd;
  logic signed [ACC_W-1:0]   prod_ext, addend, y_init, rnd, shv;
  logic [ACC_W-STATE_W:0]    hi_w;
  logic [ACC_W-SAMPLE_W:0]   hi_y;
  logic signed [STATE_W-1:0]  w_sat;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign s_hs = s_axis_tvalid && s_axis_tready;
  assign m_hs = m_axis_tvalid && m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_hs) state_d = ST_MUL_W;
      ST_MUL_W:   if (op_q == 3'd5) state_d = ST_DRAIN_W;
      ST_DRAIN_W: state_d = ST_ROUND_W;
      ST_ROUND_W: state_d = ST_MUL_Y;
      ST_MUL_Y:   if (op_q == 3'd5) state_d = ST_DRAIN_Y;
      ST_DRAIN_Y: state_d = ST_ROUND_Y;
      ST_ROUND_Y: state_d = ST_PUSH;
      ST_PUSH:    if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    phase_y       = 1'b0;
    do_round_w    = 1'b0;
    do_round_y    = 1'b0;
    push_go       = 1'b0;
    unique case (state_q)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_MUL_W:   issue = 1'b1;
      ST_DRAIN_W: ;
      ST_ROUND_W: do_round_w = 1'b1;
      ST_MUL_Y: begin
        issue   = 1'b1;
        phase_y = 1'b1;
      end
      ST_DRAIN_Y: ;
      ST_ROUND_Y: do_round_y = 1'b1;
      ST_PUSH:    push_go = !out_valid_q || m_axis_tready;
      default:    ;
    endcase
  end

  assign op_d = (issue && op_q != 3'd5) ? op_q + 3'd1 : 3'd0;

  // operand selection: op[2:1] picks the term, op[0] the half of the state word
  always_comb begin
    mul_a   = coef_a0_q;
    opnd    = STATE_W'(x_q);
    sub_sel = phase_y ? mode_q : 1'b0;
    unique case (op_q[2:1])
      2'd0: begin
        mul_a = phase_y ? coef_b0_q : coef_a0_q;
        opnd  = phase_y ? w_q : STATE_W'(x_q);
      end
      2'd1: begin
        mul_a = phase_y ? coef_b1_q : coef_a1_q;
        opnd  = d1_q;
        if (!phase_y) sub_sel = 1'b1;
      end
      2'd2: begin
        mul_a = phase_y ? coef_b2_q : coef_a2_q;
        opnd  = d2_q;
        if (!phase_y) sub_sel = 1'b1;
      end
      default: ;
    endcase
    if (op_q[0]) begin
      mul_b = MULB_W'(opnd >>> SPLIT_W);
    end else begin
      mul_b = $signed({1'b0, opnd[SPLIT_W-1:0]});
    end
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod_q);
  assign addend   = prod_hi_q ? (prod_ext <<< SPLIT_W) : prod_ext;
  assign y_init   = mode_q ? (ACC_W'(x_q) <<< COEF_FRAC) : '0;

  // shared rounding: half LSB then floor; mode one divides y by two more
  always_comb begin
    if (do_round_y && mode_q) begin
      rnd = acc_q + (ACC_W'(1) <<< COEF_FRAC);
      shv = rnd >>> (COEF_FRAC + 1);
    end else begin
      rnd = acc_q + (ACC_W'(1) <<< (COEF_FRAC - 1));
      shv = rnd >>> COEF_FRAC;
    end
    hi_w = shv[ACC_W-1:STATE_W-1];
    hi_y = shv[ACC_W-1:SAMPLE_W-1];
    if (!shv[ACC_W-1] && (|hi_w)) begin
      w_sat = {1'b0, {(STATE_W-1){1'b1}}};
    end else if (shv[ACC_W-1] && !(&hi_w)) begin
      w_sat = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      w_sat = shv[STATE_W-1:0];
    end
    if (!shv[ACC_W-1] && (|hi_y)) begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (shv[ACC_W-1] && !(&hi_y)) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = shv[SAMPLE_W-1:0];
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= 3'd0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      coef_b0_q   <= COEF_ONE;
      coef_b1_q   <= '0;
      coef_b2_q   <= '0;
      coef_a0_q   <= COEF_ONE;
      coef_a1_q   <= '0;
      coef_a2_q   <= '0;
      mode_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      pv_q    <= issue;
      if (push_go) begin
        out_valid_q <= 1'b1;
        d2_q        <= d1_q;
        d1_q        <= w_q;
      end else if (m_hs) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_B0:   coef_b0_q <= cfg_data_i;
          CFG_B1:   coef_b1_q <= cfg_data_i;
          CFG_B2:   coef_b2_q <= cfg_data_i;
          CFG_A0:   coef_a0_q <= cfg_data_i;
          CFG_A1:   coef_a1_q <= cfg_data_i;
          CFG_A2:   coef_a2_q <= cfg_data_i;
          CFG_MODE: mode_q    <= cfg_data_i[0];
          default:  ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      x_q    <= s_axis_tdata[SAMPLE_W-1:0];
      last_q <= s_axis_tlast;
    end
    if (issue) begin
      prod_q     <= prod_d;
      prod_hi_q  <= op_q[0];
      prod_sub_q <= sub_sel;
    end
    if (s_hs) begin
      acc_q <= '0;
    end else if (do_round_w) begin
      acc_q <= y_init;
    end else if (pv_q) begin
      acc_q <= prod_sub_q ? acc_q - addend : acc_q + addend;
    end
    if (do_round_w) w_q <= w_sat;
    if (do_round_y) y_q <= y_sat;
    if (push_go) begin
      out_data_q <= y_q;
      out_last_q <= last_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);
  assign m_axis_tlast  = out_last_q;

endmodule

### hdl/bqf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_checker
// Port-level checks on the biquad filter: one sample in flight at a time,
// at most two results owed, output held under stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqf_checker import bqf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [TDATA_W-1:0]   m_axis_tdata,   // [23:0] sample_out
  input logic                 m_axis_tlast    // block_end_out
);

  logic       s_hs, m_hs;
  logic [1:0] cnt_q;

  assign s_hs = s_axis_tvalid && s_axis_tready;
  assign m_hs = m_axis_tvalid && m_axis_tready;

  // results owed: transfers in minus transfers out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (s_hs && !m_hs) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (m_hs && !s_hs) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  `ASSERT_NEXT(a_busy_after_in, s_hs, !s_axis_tready)
  `ASSERT_IMP(a_owed_bound, 1'b1, cnt_q != 2'd3)
  `ASSERT_IMP(a_out_owed, m_axis_tvalid, cnt_q != 2'd0)
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind biquad_iir_filter bqf_checker u_bqf_checker (.*);
